>>> src/brf_pkg.sv
// ---------------------------------------------------------------------------
// brf_pkg
// Shared types and codes for the byte ring fifo with line detection.
// ---------------------------------------------------------------------------
package brf_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int USED_W    = 7;
  localparam int LINELEN_W = 6;

  localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_W-1:0] OP_POP       = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK      = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_LINE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    data_out;
    logic                 data_valid;
    logic                 ok;
    logic [USED_W-1:0]    used_count;
    logic                 line_found;
    logic [LINELEN_W-1:0] line_length;
    logic                 last;
  } out_word_t;

endpackage

>>> src/brf_ram.sv
// ---------------------------------------------------------------------------
// brf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/byte_ring_fifo_with_line_detect.sv
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_line_detect
// Circular byte fifo with line framing: push, pop, peek, read_line, clear.
// ---------------------------------------------------------------------------
// Input words (operation, data_in) are taken on in_valid while in_stall is
// low; in_stall is high while a word is in progress. Result words leave on
// out_valid and are taken when out_stall is low. A finished result sits in
// the output register, so the next input word is taken while it waits.
// Each input word gives one result word; a read_line gives one per line
// byte, with last set on the final one. After the line bytes, read_line
// drops a CR and then an LF at the front, where present, and rescans. The
// first CR/LF offset is tracked in registers and updated on push and pop;
// only removing that byte forces a rescan, which walks the byte RAM at one
// read per cycle.
// Reset empties the fifo; the RAM contents are left as they are. While the
// receiver stalls and the output register is full, a new result waits
// inside the block and no input word is taken.
// ---------------------------------------------------------------------------
module byte_ring_fifo_with_line_detect #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  brf_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output brf_pkg::out_word_t out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FRONT    = 3'd1;
  localparam logic [2:0] S_EMIT     = 3'd2;
  localparam logic [2:0] S_LINE_RD  = 3'd3;
  localparam logic [2:0] S_LINE     = 3'd4;
  localparam logic [2:0] S_DROP_RD  = 3'd5;
  localparam logic [2:0] S_DROP_CHK = 3'd6;
  localparam logic [2:0] S_SCAN     = 3'd7;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    adv = (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  function automatic logic is_term(input logic [brf_pkg::BYTE_W-1:0] b);
    is_term = (b == brf_pkg::CHAR_CR) || (b == brf_pkg::CHAR_LF);
  endfunction

  logic [2:0]                  state_r, state_nxt;
  logic [brf_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [AW-1:0]               wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]               fill_r, fill_nxt;
  logic                        found_r, found_nxt;
  logic [AW-1:0]               off_r, off_nxt;
  logic [brf_pkg::BYTE_W-1:0]  pend_data_r, pend_data_nxt;
  logic                        pend_dv_r, pend_dv_nxt;
  logic                        pend_ok_r, pend_ok_nxt;
  logic                        pend_last_r, pend_last_nxt;
  logic                        lf_stage_r, lf_stage_nxt;
  logic [AW-1:0]               scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0]               scan_iss_r, scan_iss_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]               chk_k_r, chk_k_nxt;
  logic                        out_vld_r, out_vld_nxt;
  brf_pkg::out_word_t          out_word_r, out_word_nxt;

  logic                        go_scan;
  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [brf_pkg::BYTE_W-1:0]  ram_rdata;

  brf_ram #(
    .WIDTH (brf_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_word.data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    fill_nxt      = fill_r;
    found_nxt     = found_r;
    off_nxt       = off_r;
    pend_data_nxt = pend_data_r;
    pend_dv_nxt   = pend_dv_r;
    pend_ok_nxt   = pend_ok_r;
    pend_last_nxt = pend_last_r;
    lf_stage_nxt  = lf_stage_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_iss_nxt  = scan_iss_r;
    chk_vld_nxt   = chk_vld_r;
    chk_k_nxt     = chk_k_r;
    out_vld_nxt   = out_vld_r && out_stall;
    out_word_nxt  = out_word_r;
    go_scan       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rd_ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_word.operation;
          pend_data_nxt = '0;
          pend_dv_nxt   = 1'b0;
          pend_ok_nxt   = 1'b0;
          pend_last_nxt = 1'b1;
          state_nxt     = S_EMIT;
          case (in_word.operation)
            brf_pkg::OP_PUSH: begin
              if (fill_r != FULL) begin
                ram_we      = 1'b1;
                wr_ptr_nxt  = adv(wr_ptr_r);
                fill_nxt    = fill_r + CW'(1);
                pend_ok_nxt = 1'b1;
                if (!found_r && is_term(in_word.data_in)) begin
                  found_nxt = 1'b1;
                  off_nxt   = fill_r[AW-1:0];
                end
              end
            end
            brf_pkg::OP_POP, brf_pkg::OP_PEEK: begin
              if (fill_r != '0) begin
                ram_re    = 1'b1;
                state_nxt = S_FRONT;
              end
            end
            brf_pkg::OP_READ_LINE: begin
              if (found_r) begin
                pend_ok_nxt = 1'b1;
                if (off_r == '0) begin
                  lf_stage_nxt = 1'b0;
                  state_nxt    = S_DROP_RD;
                end else begin
                  state_nxt = S_LINE_RD;
                end
              end
            end
            brf_pkg::OP_CLEAR: begin
              wr_ptr_nxt  = '0;
              rd_ptr_nxt  = '0;
              fill_nxt    = '0;
              found_nxt   = 1'b0;
              off_nxt     = '0;
              pend_ok_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_FRONT: begin
        pend_data_nxt = ram_rdata;
        pend_dv_nxt   = 1'b1;
        pend_ok_nxt   = 1'b1;
        state_nxt     = S_EMIT;
        if (op_r == brf_pkg::OP_POP) begin
          rd_ptr_nxt = adv(rd_ptr_r);
          fill_nxt   = fill_r - CW'(1);
          if (found_r) begin
            if (off_r == '0) begin
              go_scan   = 1'b1;
              state_nxt = S_SCAN;
            end else begin
              off_nxt = off_r - AW'(1);
            end
          end
        end
      end
      S_EMIT: begin
        if (!out_vld_r || !out_stall) begin
          out_vld_nxt              = 1'b1;
          out_word_nxt.data_out    = pend_data_r;
          out_word_nxt.data_valid  = pend_dv_r;
          out_word_nxt.ok          = pend_ok_r;
          out_word_nxt.used_count  = brf_pkg::USED_W'(fill_r);
          out_word_nxt.line_found  = found_r;
          out_word_nxt.line_length = brf_pkg::LINELEN_W'(off_r);
          out_word_nxt.last        = pend_last_r;
          state_nxt                = pend_last_r ? S_IDLE : S_LINE_RD;
        end
      end
      S_LINE_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_LINE;
      end
      S_LINE: begin
        pend_data_nxt = ram_rdata;
        pend_dv_nxt   = 1'b1;
        pend_ok_nxt   = 1'b1;
        rd_ptr_nxt    = adv(rd_ptr_r);
        fill_nxt      = fill_r - CW'(1);
        off_nxt       = off_r - AW'(1);
        if (off_r == AW'(1)) begin
          pend_last_nxt = 1'b1;
          lf_stage_nxt  = 1'b0;
          state_nxt     = S_DROP_RD;
        end else begin
          pend_last_nxt = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_DROP_RD: begin
        if (fill_r == '0) begin
          go_scan   = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_DROP_CHK;
        end
      end
      S_DROP_CHK: begin
        if (ram_rdata == (lf_stage_r ? brf_pkg::CHAR_LF : brf_pkg::CHAR_CR)) begin
          rd_ptr_nxt = adv(rd_ptr_r);
          fill_nxt   = fill_r - CW'(1);
        end
        if (lf_stage_r) begin
          go_scan   = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          lf_stage_nxt = 1'b1;
          state_nxt    = S_DROP_RD;
        end
      end
      S_SCAN: begin
        ram_raddr = scan_ptr_r;
        if (chk_vld_r && is_term(ram_rdata)) begin
          found_nxt   = 1'b1;
          off_nxt     = chk_k_r;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end else if (scan_iss_r < fill_r) begin
          ram_re       = 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_k_nxt    = scan_iss_r[AW-1:0];
          scan_iss_nxt = scan_iss_r + CW'(1);
          scan_ptr_nxt = adv(scan_ptr_r);
        end else if (chk_vld_r) begin
          chk_vld_nxt = 1'b0;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // rescan starts from the read pointer left after this cycle
    if (go_scan) begin
      found_nxt    = 1'b0;
      off_nxt      = '0;
      scan_iss_nxt = '0;
      chk_vld_nxt  = 1'b0;
      scan_ptr_nxt = rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fill_r     <= '0;
      found_r    <= 1'b0;
      off_r      <= '0;
      chk_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      fill_r     <= fill_nxt;
      found_r    <= found_nxt;
      off_r      <= off_nxt;
      chk_vld_r  <= chk_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pend_data_r <= pend_data_nxt;
    pend_dv_r   <= pend_dv_nxt;
    pend_ok_r   <= pend_ok_nxt;
    pend_last_r <= pend_last_nxt;
    lf_stage_r  <= lf_stage_nxt;
    scan_ptr_r  <= scan_ptr_nxt;
    scan_iss_r  <= scan_iss_nxt;
    chk_k_r     <= chk_k_nxt;
    out_word_r  <= out_word_nxt;
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count above depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0 || fill_r == FULL) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers disagree with fill count");

  a_off_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (off_r == '0))
    else $error("line offset set without a line");

  // the terminator drop runs ahead of the rescan that refreshes the flag
  a_off_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && state_r != S_DROP_RD && state_r != S_DROP_CHK)
      |-> (CW'(off_r) < fill_r))
    else $error("line offset beyond held bytes");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> (out_vld_r && $stable(out_word_r)))
    else $error("stalled result word changed");

endmodule

>>> tb/tb_byte_ring_fifo_with_line_detect.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_byte_ring_fifo_with_line_detect
// Self-checking bench for the byte ring fifo with line detection. Input words
// are driven through the valid/stall handshake and run through a behavioral
// model of the ring (pointers, fill count, first CR/LF search). Every result
// word is compared field by field with the oldest predicted word. Directed
// corner cases come first, then a full-ring pass and random line traffic,
// with random gaps on both sides.
// ---------------------------------------------------------------------------
module tb_byte_ring_fifo_with_line_detect;

  localparam int RING_DEPTH     = brf_pkg::DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 200;

  localparam logic [brf_pkg::OP_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [brf_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [brf_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  brf_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  brf_pkg::out_word_t out_word;

  int                 fail_count  = 0;
  int                 items_sent  = 0;
  int                 stall_left  = 0;
  int                 quiet_cycles = 0;
  brf_pkg::out_word_t expected_results[$];

  // ring model
  logic [brf_pkg::BYTE_W-1:0] fifo_bytes [RING_DEPTH];
  logic [5:0]                 wr_ptr = '0;
  logic [5:0]                 rd_ptr = '0;
  int                         fill   = 0;

  byte_ring_fifo_with_line_detect dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  function automatic bit is_term(input logic [brf_pkg::BYTE_W-1:0] b);
    return (b == brf_pkg::CHAR_CR) || (b == brf_pkg::CHAR_LF);
  endfunction

  task automatic scan_first_term(output bit found, output int offs);
    logic [5:0] p;
    p = rd_ptr;
    found = 1'b0;
    offs = 0;
    for (int k = 0; k < fill; k++) begin
      if (is_term(fifo_bytes[p])) begin
        found = 1'b1;
        offs = k;
        return;
      end
      p = p + 1'b1;
    end
  endtask

  task automatic append_result(input logic [brf_pkg::BYTE_W-1:0] d, input logic v,
                               input logic k, input logic lst);
    brf_pkg::out_word_t r;
    bit                 found;
    int                 offs;
    scan_first_term(found, offs);
    r.data_out    = d;
    r.data_valid  = v;
    r.ok          = k;
    r.used_count  = brf_pkg::USED_W'(fill);
    r.line_found  = found;
    r.line_length = brf_pkg::LINELEN_W'(offs);
    r.last        = lst;
    expected_results.push_back(r);
  endtask

  task automatic take_front(output logic [brf_pkg::BYTE_W-1:0] b);
    b = fifo_bytes[rd_ptr];
    rd_ptr = rd_ptr + 1'b1;
    fill--;
  endtask

  task automatic drop_terminator();
    logic [brf_pkg::BYTE_W-1:0] b;
    if (fill > 0 && fifo_bytes[rd_ptr] == brf_pkg::CHAR_CR) take_front(b);
    if (fill > 0 && fifo_bytes[rd_ptr] == brf_pkg::CHAR_LF) take_front(b);
  endtask

  task automatic predict_word(input brf_pkg::in_word_t w);
    bit                         found;
    int                         len;
    logic [brf_pkg::BYTE_W-1:0] b;
    case (w.operation)
      brf_pkg::OP_PUSH: begin
        if (fill >= RING_DEPTH) begin
          append_result('0, 1'b0, 1'b0, 1'b1);
        end else begin
          fifo_bytes[wr_ptr] = w.data_in;
          wr_ptr = wr_ptr + 1'b1;
          fill++;
          append_result('0, 1'b0, 1'b1, 1'b1);
        end
      end
      brf_pkg::OP_POP, brf_pkg::OP_PEEK: begin
        if (fill == 0) begin
          append_result('0, 1'b0, 1'b0, 1'b1);
        end else begin
          if (w.operation == brf_pkg::OP_POP) take_front(b);
          else b = fifo_bytes[rd_ptr];
          append_result(b, 1'b1, 1'b1, 1'b1);
        end
      end
      brf_pkg::OP_READ_LINE: begin
        scan_first_term(found, len);
        if (!found) begin
          append_result('0, 1'b0, 1'b0, 1'b1);
        end else if (len == 0) begin
          drop_terminator();
          append_result('0, 1'b0, 1'b1, 1'b1);
        end else begin
          for (int k = 0; k < len; k++) begin
            take_front(b);
            if (k == len - 1) begin
              drop_terminator();
              append_result(b, 1'b1, 1'b1, 1'b1);
            end else begin
              append_result(b, 1'b1, 1'b1, 1'b0);
            end
          end
        end
      end
      brf_pkg::OP_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        fill = 0;
        append_result('0, 1'b0, 1'b1, 1'b1);
      end
      default: append_result('0, 1'b0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic send_word(input logic [brf_pkg::OP_W-1:0] op,
                           input logic [brf_pkg::BYTE_W-1:0] d);
    int                gap;
    brf_pkg::in_word_t w;
    w.operation = op;
    w.data_in   = d;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_word(w);
    items_sent++;
  endtask

  function automatic logic [brf_pkg::BYTE_W-1:0] plain_byte();
    logic [brf_pkg::BYTE_W-1:0] b;
    do b = brf_pkg::BYTE_W'($urandom_range(0, 255)); while (is_term(b));
    return b;
  endfunction

  function automatic logic [brf_pkg::OP_W-1:0] rand_op();
    return brf_pkg::OP_W'($urandom_range(0, 7));
  endfunction

  task automatic send_terminator();
    case ($urandom_range(0, 4))
      0: send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_CR);
      1: send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_LF);
      2: begin
        send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_CR);
        send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_LF);
      end
      3: begin
        send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_LF);
        send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_CR);
      end
      default: begin
        send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_CR);
        send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_CR);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  task automatic check_result(input brf_pkg::out_word_t got);
    brf_pkg::out_word_t exp_w;
    if (expected_results.size() == 0) begin
      $error("result word with nothing pending: %h", got);
      fail_count++;
    end else begin
      exp_w = expected_results.pop_front();
      check_field("data_out", exp_w.data_out, got.data_out);
      check_field("data_valid", exp_w.data_valid, got.data_valid);
      check_field("ok", exp_w.ok, got.ok);
      check_field("used_count", exp_w.used_count, got.used_count);
      check_field("line_found", exp_w.line_found, got.line_found);
      check_field("line_length", exp_w.line_length, got.line_length);
      check_field("last", exp_w.last, got.last);
    end
  endtask

  // result side: check each accepted word, then maybe stall
  always @(posedge clk) begin
    int hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid === 1'b1 && !out_stall) begin
      check_result(out_word);
      hold = $urandom_range(0, 5);
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_ops();
    send_word(brf_pkg::OP_POP, 8'h00);
    send_word(brf_pkg::OP_PEEK, 8'hff);
    send_word(brf_pkg::OP_READ_LINE, 8'h00);
    send_word(OP_UNUSED_5, 8'h55);
    send_word(OP_UNUSED_6, 8'haa);
    send_word(OP_UNUSED_7, 8'hff);
  endtask

  task automatic test_push_pop();
    send_word(brf_pkg::OP_PUSH, 8'h00);
    send_word(brf_pkg::OP_PUSH, 8'hff);
    send_word(brf_pkg::OP_PEEK, 8'h00);
    send_word(brf_pkg::OP_POP, 8'h00);
    send_word(brf_pkg::OP_POP, 8'h00);
  endtask

  task automatic test_line_cases();
    // line with CRLF, empty LF line, CR CR keeps one CR, no terminator
    send_word(brf_pkg::OP_PUSH, 8'h61);
    send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_CR);
    send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_LF);
    send_word(brf_pkg::OP_READ_LINE, 8'h00);
    send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_LF);
    send_word(brf_pkg::OP_READ_LINE, 8'h00);
    send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_CR);
    send_word(brf_pkg::OP_PUSH, brf_pkg::CHAR_CR);
    send_word(brf_pkg::OP_READ_LINE, 8'h00);
    send_word(brf_pkg::OP_READ_LINE, 8'h00);
    send_word(brf_pkg::OP_PUSH, 8'h78);
    send_word(brf_pkg::OP_READ_LINE, 8'h00);
    send_word(brf_pkg::OP_CLEAR, 8'h00);
  endtask

  task automatic test_full_ring();
    send_word(brf_pkg::OP_CLEAR, 8'h00);
    repeat (3) send_word(brf_pkg::OP_PUSH, plain_byte());
    repeat (3) send_word(brf_pkg::OP_POP, 8'h00);
    repeat (RING_DEPTH - 1) send_word(brf_pkg::OP_PUSH, plain_byte());
    send_word(brf_pkg::OP_PUSH,
              ($urandom_range(0, 1) != 0) ? brf_pkg::CHAR_CR : brf_pkg::CHAR_LF);
    send_word(brf_pkg::OP_PUSH, plain_byte());
    send_word(brf_pkg::OP_PEEK, 8'h00);
    send_word(brf_pkg::OP_READ_LINE, 8'h00);
    send_word(brf_pkg::OP_POP, 8'h00);
  endtask

  task automatic test_random_traffic(input int n_items);
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 10)) send_word(brf_pkg::OP_PUSH, plain_byte());
        send_terminator();
        if ($urandom_range(0, 3) != 0) send_word(brf_pkg::OP_READ_LINE, 8'h00);
      end else begin
        send_word(rand_op(), brf_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_ops();
    test_push_pop();
    test_line_cases();
    test_full_ring();
    test_random_traffic(50);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/brf_pkg.sv
src/brf_ram.sv
src/byte_ring_fifo_with_line_detect.sv
tb/tb_byte_ring_fifo_with_line_detect.sv
